/* hdl/bgw_pkg.sv */
// Register map, fixed field widths and reset values for the B-spline weight block.
package bgw_pkg;

   localparam int COORD_W    = 32;
   localparam int DER_W      = 48;
   localparam int GRID_W     = 16;
   localparam int SCALE_W    = 32;
   localparam int TOL_W      = 8;
   localparam int ORDER_W    = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // register indexes, byte address is four times the index
   localparam logic [2:0] REG_PERIODIC = 3'd0;
   localparam logic [2:0] REG_ORDER    = 3'd1;
   localparam logic [2:0] REG_GRID     = 3'd2;
   localparam logic [2:0] REG_PSCALE   = 3'd3;
   localparam logic [2:0] REG_DSCALE   = 3'd4;
   localparam logic [2:0] REG_TOL      = 3'd5;

   localparam logic [ORDER_W-1:0] ORDER_RST  = 4'd4;
   localparam logic [GRID_W-1:0]  GRID_RST   = 16'd64;
   localparam logic [SCALE_W-1:0] PSCALE_RST = 32'd65536;
   localparam logic [SCALE_W-1:0] DSCALE_RST = 32'd65536;
   localparam logic [TOL_W-1:0]   TOL_RST    = 8'd1;

endpackage

/* hdl/bspline_grid_weights.sv */
// Top level: cardinal B-spline weights, derivatives and node indexes per coordinate.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  req     | in        | req_valid / req_stall | req_coordinate (signed Q16.16)
//  rsp     | out       | rsp_valid / rsp_stall | rsp_weight, rsp_weight_derivative,
//          |           |                       | rsp_node_index, rsp_index_error, rsp_last
//  csr     | in/out    | psel / penable        | paddr, pwrite, pwdata, prdata, pready
//
//  One coordinate yields spline_order results (1..MAX_ORDER), one per cycle unless the
//  result channel stalls; the serialiser that feeds the result channel sets the rate. The
//  core pipeline depth is CORE_ST, where
//  CORE_ST = max(2*(MAX_ORDER-1), 11): two stages per recursion pass, and the remainder
//  pipeline that wraps the first node index in periodic mode (four bits per stage).
//  Reset is synchronous, clears every valid bit and the CSR registers; there is no sweep.
//  A stall on the result channel holds the output register and the serialiser; while the
//  last core stage holds a coordinate the serialiser cannot yet take, hold every front and
//  core stage, bubbles included, and stall the request side.
module bspline_grid_weights #(
   parameter int MAX_ORDER     = 8,
   parameter int INDEX_BITS    = 16,
   parameter int FRACTION_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [bgw_pkg::COORD_W-1:0]     req_coordinate,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [FRACTION_BITS:0]                 rsp_weight,
   output logic signed [bgw_pkg::DER_W-1:0]       rsp_weight_derivative,
   output logic [INDEX_BITS-1:0]                  rsp_node_index,
   output logic                                   rsp_index_error,
   output logic                                   rsp_last,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [bgw_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [bgw_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [bgw_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);
   import bgw_pkg::*;

   localparam int FW  = FRACTION_BITS;
   localparam int FW1 = FW + 1;
   localparam int FW2 = FW + 2;
   localparam int OW  = $clog2(MAX_ORDER + 1);
   // coefficient width (n*ONE), numerator width and reciprocal shift for the pass divide
   localparam int AW  = FW + $clog2(MAX_ORDER) + 1;
   localparam int NW  = AW + 1;
   localparam int SH  = NW + 4;
   localparam int NODE_W  = 34;
   localparam int MAG_W   = NODE_W + 2;
   localparam int MOD_ST  = MAG_W / 4;
   localparam int PASS_ST = 2 * (MAX_ORDER - 1);
   localparam int CORE_ST = (PASS_ST > MOD_ST + 2) ? PASS_ST : MOD_ST + 2;
   localparam int PW  = FW + 17;
   localparam int SW  = (PW > 49) ? PW : 49;

   localparam logic [FW:0]   ONE_Q   = {1'b1, {FW{1'b0}}};
   localparam logic [FW:0]   HALF_Q  = ONE_Q >> 1;
   localparam logic [SW-1:0] NEG_LIM = SW'(1) << 47;
   localparam logic [SW-1:0] POS_LIM = NEG_LIM - SW'(1);

   typedef struct packed {
      logic [FW:0]                     frac;
      logic [MAX_ORDER-1:0][FW:0]      wt;
      logic [MAX_ORDER-1:0][FW:0]      pw;
      logic [MAX_ORDER-1:0][NW-1:0]    num;
      logic signed [NODE_W-1:0]        first;
      logic [MAG_W-1:0]                mag;
      logic                            neg;
      logic [16:0]                     rem;
      logic [15:0]                     base;
   } core_type;

   // ---------------------------------------------------------------- registers
   logic                 periodic_ff;
   logic [ORDER_W-1:0]   order_ff;
   logic [GRID_W-1:0]    grid_ff;
   logic [SCALE_W-1:0]   pscale_ff;
   logic [SCALE_W-1:0]   dscale_ff;
   logic [TOL_W-1:0]     tol_ff;
   logic                 csr_wr;

   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         periodic_ff <= 1'b0;
         order_ff    <= ORDER_RST;
         grid_ff     <= GRID_RST;
         pscale_ff   <= PSCALE_RST;
         dscale_ff   <= DSCALE_RST;
         tol_ff      <= TOL_RST;
      end else if (csr_wr) begin
         case (paddr[4:2])
            REG_PERIODIC: periodic_ff <= pwdata[0];
            REG_ORDER:    order_ff    <= pwdata[ORDER_W-1:0];
            REG_GRID:     grid_ff     <= pwdata[GRID_W-1:0];
            REG_PSCALE:   pscale_ff   <= pwdata;
            REG_DSCALE:   dscale_ff   <= pwdata;
            REG_TOL:      tol_ff      <= pwdata[TOL_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_PERIODIC: prdata = {31'd0, periodic_ff};
         REG_ORDER:    prdata = {28'd0, order_ff};
         REG_GRID:     prdata = {16'd0, grid_ff};
         REG_PSCALE:   prdata = pscale_ff;
         REG_DSCALE:   prdata = dscale_ff;
         REG_TOL:      prdata = {24'd0, tol_ff};
         default:      prdata = '0;
      endcase
   end

   // effective order, grid size; change registers only while the block is idle (unchecked)
   logic [4:0]  ord5;
   logic [16:0] nx;

   always_comb begin
      ord5 = (order_ff == '0) ? 5'd1 : {1'b0, order_ff};
      if (ord5 > MAX_ORDER[4:0]) ord5 = MAX_ORDER[4:0];
   end

   assign nx = (grid_ff < 16'd2) ? 17'd2 : {1'b0, grid_ff};

   // ---------------------------------------------------------------- flow control
   logic                  pipe_en;
   logic                  tail_en;
   logic                  ser_vld_ff;
   logic                  ser_last;
   logic                  ser_emit;
   logic                  ser_load_ok;
   logic                  ser_load;
   logic [CORE_ST:0]      vld_ff;

   assign tail_en     = !rsp_valid || !rsp_stall;
   assign ser_emit    = ser_vld_ff && tail_en;
   assign ser_load_ok = !ser_vld_ff || (ser_emit && ser_last);
   assign ser_load    = vld_ff[CORE_ST] && ser_load_ok;
   assign pipe_en     = !vld_ff[CORE_ST] || ser_load_ok;
   assign req_stall   = !pipe_en;

   // ---------------------------------------------------------------- front stages
   logic                 s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic signed [64:0]   s1_prod;
   logic [63:0]          s1_x_ff;
   logic [63:0]          s2_xs;
   logic signed [31:0]   s2_ilo_ff;
   logic [FW:0]          s2_frac_ff;
   logic signed [NODE_W-1:0] s3_ilo_w, s3_lo_lim, s3_ilo_in, s3_ilo_ff;
   logic [FW:0]          s3_frac_in, s3_frac_ff;

   // position in cells, exact Q32.32
   assign s1_prod = req_coordinate * $signed({1'b0, pscale_ff});
   // odd orders sit half a cell lower
   assign s2_xs   = s1_x_ff - (ord5[0] ? 64'h0000_0000_8000_0000 : 64'd0);

   // end nudges on an aperiodic grid
   always_comb begin
      s3_ilo_w   = NODE_W'(s2_ilo_ff);
      s3_lo_lim  = $signed({18'd0, nx[16:1]}) - 34'sd1;
      s3_ilo_in  = s3_ilo_w;
      s3_frac_in = s2_frac_ff;
      if (!periodic_ff) begin
         if (s3_ilo_w < s3_lo_lim) begin
            if (({1'b0, s2_frac_ff} + FW2'(tol_ff)) > {1'b0, ONE_Q}) begin
               s3_ilo_in  = s3_ilo_w + 34'sd1;
               s3_frac_in = '0;
            end
         end else if ((s3_ilo_w + $signed({30'd0, ord5[4:1]})) == $signed({17'd0, nx})) begin
            if (s2_frac_ff < FW1'(tol_ff)) begin
               s3_ilo_in  = s3_ilo_w - 34'sd1;
               s3_frac_in = ONE_Q;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_x_ff    <= s1_prod[63:0];
         s2_ilo_ff  <= s2_xs[63:32];
         s2_frac_ff <= {1'b0, s2_xs[31 -: FW]};
         s3_ilo_ff  <= s3_ilo_in;
         s3_frac_ff <= s3_frac_in;
      end
   end

   // ---------------------------------------------------------------- core pipeline
   // stage 0 holds the first node and the order-1 spline; later stages run the
   // recursion passes (product, then divide) beside the index remainder
   core_type stage_ff [CORE_ST+1];
   core_type stage_in [CORE_ST+1];

   always_comb begin
      logic signed [NODE_W-1:0] adj;
      if (ord5 == 5'd1) begin
         adj = (s3_frac_ff >= HALF_Q) ? 34'sd1 : 34'sd0;
      end else begin
         adj = 34'sd1 - $signed({30'd0, ord5[4:1]});
      end
      stage_in[0]       = '0;
      stage_in[0].frac  = s3_frac_ff;
      stage_in[0].wt[0] = ONE_Q;
      stage_in[0].first = s3_ilo_ff + adj;
   end

   for (genvar j = 1; j <= CORE_ST; j++) begin : g_core
      localparam int  K       = j - 1;
      localparam bit  DO_MUL  = (K < PASS_ST) && (K % 2 == 0);
      localparam bit  DO_DIV  = (K < PASS_ST) && (K % 2 == 1);
      localparam int  N       = 2 + K / 2;
      localparam int  D       = (N > 1) ? N - 1 : 1;
      localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D);
      localparam bit  DO_SIGN = (K == 0);
      localparam bit  DO_MOD  = (K >= 1) && (K <= MOD_ST);
      localparam int  DIG     = DO_MOD ? K - 1 : 0;
      localparam bit  DO_BASE = (K == MOD_ST + 1);

      always_comb begin
         core_type                   src;
         logic [MAX_ORDER-1:0][FW:0] lsh;
         logic [AW-1:0]              al, ar;
         logic [AW+FW:0]             pl, pr;
         logic [NW-1:0]              m, q;
         logic [NW+SH-1:0]           dprod;
         logic [16:0]                r;
         logic [NODE_W-1:0]          fabs;
         src   = stage_ff[j-1];
         lsh   = src.wt << FW1;
         al    = '0;
         ar    = '0;
         pl    = '0;
         pr    = '0;
         m     = '0;
         q     = '0;
         dprod = '0;
         r     = src.rem;
         fabs  = '0;
         stage_in[j] = src;
         if (DO_MUL) begin
            if (ord5 >= 5'(N)) stage_in[j].pw = src.wt;
            for (int i = 0; i < MAX_ORDER; i++) begin
               if (i < N) begin
                  al = (AW'(N - 1 - i) << FW) + AW'(src.frac);
                  ar = (AW'(i + 1) << FW) - AW'(src.frac);
                  pl = al * lsh[i];
                  pr = ar * src.wt[i];
                  stage_in[j].num[i] = NW'(pl >> FW) + NW'(pr >> FW);
               end
            end
         end
         if (DO_DIV && (ord5 >= 5'(N))) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
               if (i < N) begin
                  m = src.num[i] + NW'(D / 2);
                  if (D == 1) begin
                     q = m;
                  end else begin
                     dprod = m * RECIP[SH-1:0];
                     q     = dprod[NW+SH-1:SH];
                  end
                  stage_in[j].wt[i] = (q > NW'(ONE_Q)) ? ONE_Q : q[FW:0];
               end
            end
         end
         if (DO_SIGN) begin
            fabs = src.first[NODE_W-1] ? NODE_W'(-src.first) : NODE_W'(src.first);
            stage_in[j].neg = src.first[NODE_W-1];
            stage_in[j].mag = {2'b00, fabs};
            stage_in[j].rem = '0;
         end
         if (DO_MOD) begin
            for (int s = 0; s < 4; s++) begin
               r = {r[15:0], src.mag[MAG_W-1-4*DIG-s]};
               if (r >= nx) r = r - nx;
            end
            stage_in[j].rem = r;
         end
         if (DO_BASE) begin
            stage_in[j].base = (src.neg && (src.rem != '0)) ? 16'(nx - src.rem)
                                                            : src.rem[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[CORE_ST-1:0], s3_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int j = 0; j <= CORE_ST; j++) stage_ff[j] <= stage_in[j];
      end
   end

   // ---------------------------------------------------------------- serialiser
   // shift the weight vectors down one lane per result; keep the lane below for the
   // derivative and a running node number
   logic [MAX_ORDER-1:0][FW:0]  ser_wt_ff, ser_pw_ff;
   logic [FW:0]                 ser_pprev_ff;
   logic [OW-1:0]               ser_cnt_ff;
   logic signed [NODE_W-1:0]    ser_node_ff, ser_node_in;

   assign ser_last = (5'(ser_cnt_ff) == (ord5 - 5'd1));

   always_comb begin
      ser_node_in = ser_node_ff + 34'sd1;
      if (periodic_ff && (ser_node_in == $signed({17'd0, nx}))) ser_node_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
      end else if (ser_load) begin
         ser_vld_ff <= 1'b1;
      end else if (ser_emit && ser_last) begin
         ser_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_wt_ff    <= stage_ff[CORE_ST].wt;
         ser_pw_ff    <= stage_ff[CORE_ST].pw;
         ser_pprev_ff <= '0;
         ser_cnt_ff   <= '0;
         ser_node_ff  <= periodic_ff ? $signed({18'd0, stage_ff[CORE_ST].base})
                                     : stage_ff[CORE_ST].first;
      end else if (ser_emit) begin
         ser_wt_ff    <= ser_wt_ff >> FW1;
         ser_pw_ff    <= ser_pw_ff >> FW1;
         ser_pprev_ff <= ser_pw_ff[0];
         ser_cnt_ff   <= ser_cnt_ff + OW'(1);
         ser_node_ff  <= ser_node_in;
      end
   end

   // ---------------------------------------------------------------- result tail
   logic                    t1_vld_ff, t2_vld_ff, rsp_valid_ff;
   logic [FW:0]             t1_wt_ff, t2_wt_ff, rsp_weight_ff;
   logic signed [FW+1:0]    t1_d_in, t1_d_ff;
   logic [INDEX_BITS-1:0]   t1_idx_ff, t2_idx_ff, rsp_idx_ff;
   logic                    t1_err_in, t1_err_ff, t2_err_ff, rsp_err_ff;
   logic                    t1_last_ff, t2_last_ff, rsp_last_ff;
   logic [FW:0]             t2_dmag;
   logic [FW+32:0]          t2_dprod;
   logic [PW-1:0]           t2_p_ff;
   logic                    t2_neg_ff;
   logic [SW-1:0]           t3_pe, t3_sat;
   logic signed [DER_W-1:0] t3_der_in, rsp_der_ff;

   assign t1_d_in   = (ord5 == 5'd1) ? '0
                    : $signed({1'b0, ser_pprev_ff}) - $signed({1'b0, ser_pw_ff[0]});
   assign t1_err_in = !periodic_ff && ((ser_node_ff < 34'sd0) ||
                      (ser_node_ff > ($signed({17'd0, nx}) - 34'sd1)));

   assign t2_dmag  = t1_d_ff[FW+1] ? FW1'(-t1_d_ff) : t1_d_ff[FW:0];
   assign t2_dprod = t2_dmag * dscale_ff;

   // saturate to the signed 48-bit range, sign restored after truncation toward zero
   always_comb begin
      t3_pe = SW'(t2_p_ff);
      if (t2_neg_ff) begin
         t3_sat    = (t3_pe > NEG_LIM) ? NEG_LIM : t3_pe;
         t3_der_in = DER_W'(-t3_sat);
      end else begin
         t3_sat    = (t3_pe > POS_LIM) ? POS_LIM : t3_pe;
         t3_der_in = DER_W'(t3_sat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_vld_ff    <= 1'b0;
         t2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (tail_en) begin
         t1_vld_ff    <= ser_vld_ff;
         t2_vld_ff    <= t1_vld_ff;
         rsp_valid_ff <= t2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tail_en) begin
         t1_wt_ff      <= ser_wt_ff[0];
         t1_d_ff       <= t1_d_in;
         t1_idx_ff     <= ser_node_ff[INDEX_BITS-1:0];
         t1_err_ff     <= t1_err_in;
         t1_last_ff    <= ser_last;
         t2_wt_ff      <= t1_wt_ff;
         t2_p_ff       <= t2_dprod[FW+32:16];
         t2_neg_ff     <= t1_d_ff[FW+1];
         t2_idx_ff     <= t1_idx_ff;
         t2_err_ff     <= t1_err_ff;
         t2_last_ff    <= t1_last_ff;
         rsp_weight_ff <= t2_wt_ff;
         rsp_der_ff    <= t3_der_in;
         rsp_idx_ff    <= t2_idx_ff;
         rsp_err_ff    <= t2_err_ff;
         rsp_last_ff   <= t2_last_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_weight            = rsp_weight_ff;
   assign rsp_weight_derivative = rsp_der_ff;
   assign rsp_node_index        = rsp_idx_ff;
   assign rsp_index_error       = rsp_err_ff;
   assign rsp_last              = rsp_last_ff;

   // ---------------------------------------------------------------- assertions
   a_weight_le_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weight <= ONE_Q))
      else $error("weight above one");

   a_drained_no_stall: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[CORE_ST] |-> !req_stall)
      else $error("request stalled with empty pipeline tail");

   a_ser_hold: assert property (@(posedge clock) disable iff (reset)
      (ser_vld_ff && !tail_en) |=> (ser_vld_ff && $stable(ser_cnt_ff)))
      else $error("serialiser moved while result side stalled");

   a_ser_wrap: assert property (@(posedge clock) disable iff (reset)
      (ser_emit && ser_last) |=> (!ser_vld_ff || (ser_cnt_ff == '0)))
      else $error("serialiser did not restart after final node");

endmodule

/* bench/bgw_checker.sv */
// Result checker for the B-spline weight block: snoops registers, predicts node results, compares.
module bgw_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [bgw_pkg::COORD_W-1:0]  req_coordinate,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [24:0]                         rsp_weight,
   input  logic signed [bgw_pkg::DER_W-1:0]    rsp_weight_derivative,
   input  logic [15:0]                         rsp_node_index,
   input  logic                                rsp_index_error,
   input  logic                                rsp_last,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic                                pready,
   input  logic [bgw_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [bgw_pkg::CSR_DATA_W-1:0]      pwdata,
   output int                                  fail_count,
   output int                                  results_due
);
   import bgw_pkg::*;

   localparam longint unsigned ONE_W = 64'd1 << 24;

   typedef struct packed {
      logic [24:0]      weight;
      logic [DER_W-1:0] slope;
      logic [15:0]      node;
      logic             off_grid;
      logic             last;
   } node_result_type;

   node_result_type nodes_due[$];

   bit               periodic_ff;
   bit [ORDER_W-1:0] order_ff;
   bit [GRID_W-1:0]  grid_ff;
   bit [SCALE_W-1:0] pscale_ff;
   bit [SCALE_W-1:0] dscale_ff;
   bit [TOL_W-1:0]   tol_ff;

   longint unsigned spl[8];

   initial fail_count = 0;
   assign results_due = nodes_due.size();

   function automatic longint unsigned mul_q(longint unsigned a, longint unsigned b);
      return (a * (b >> 16) + ((a * (b & 64'hFFFF)) >> 16)) >> 8;
   endfunction

   // raise the spline held in spl to order n
   function automatic void raise_order(longint unsigned w, int unsigned n);
      int unsigned i;
      longint unsigned left, num, v;
      for (int unsigned k = n; k > 0; k--) begin
         i = k - 1;
         left = (i > 0) ? spl[i-1] : 64'd0;
         num = mul_q(longint'(n - 1 - i) * ONE_W + w, left)
             + mul_q(longint'(i + 1) * ONE_W - w, spl[i]);
         v = (num + (n - 1) / 2) / (n - 1);
         spl[i] = (v > ONE_W) ? ONE_W : v;
      end
   endfunction

   function automatic logic [DER_W-1:0] scale_slope(longint d);
      longint unsigned mag, p, s;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      s = longint'(dscale_ff);
      p = mag * (s >> 16) + ((mag * (s & 64'hFFFF)) >> 16);
      if (d < 0) begin
         if (p > (64'd1 << 47)) p = 64'd1 << 47;
         return DER_W'(-p);
      end
      if (p > (64'd1 << 47) - 1) p = (64'd1 << 47) - 1;
      return DER_W'(p);
   endfunction

   function automatic void predict_nodes(logic signed [COORD_W-1:0] coord);
      int unsigned ord;
      longint nx, x, ilo, first, base, node;
      longint unsigned frac;
      longint slope[8];
      node_result_type r;
      ord = (order_ff == 0) ? 1 : (order_ff > 8) ? 8 : order_ff;
      nx = (grid_ff < 2) ? 2 : longint'(grid_ff);
      x = longint'(coord) * longint'(pscale_ff);
      if (ord % 2 == 1) x = x - 64'sd2147483648;
      ilo = x >>> 32;
      frac = longint'(x[31:0]) >> 8;
      // end nudges on an open grid
      if (!periodic_ff) begin
         if (ilo < nx / 2 - 1) begin
            if (frac + tol_ff > ONE_W) begin
               ilo = ilo + 1;
               frac = 0;
            end
         end else if (ilo + 1 - longint'((ord + 1) / 2) + longint'(ord - 1) == nx) begin
            if (frac < tol_ff) begin
               ilo = ilo - 1;
               frac = ONE_W;
            end
         end
      end
      for (int j = 0; j < 8; j++) begin
         spl[j] = 0;
         slope[j] = 0;
      end
      spl[0] = ONE_W;
      if (ord == 1) begin
         first = (frac < ONE_W / 2) ? ilo : ilo + 1;
      end else begin
         for (int unsigned n = 2; n < ord; n++) raise_order(frac, n);
         slope[0] = -longint'(spl[0]);
         for (int unsigned n = 1; n + 1 < ord; n++)
            slope[n] = longint'(spl[n-1]) - longint'(spl[n]);
         slope[ord-1] = longint'(spl[ord-2]);
         raise_order(frac, ord);
         first = ilo + 1 - longint'(ord / 2);
      end
      base = first % nx;
      if (base < 0) base = base + nx;
      for (int unsigned b = 0; b < ord; b++) begin
         node = first + b;
         r.weight = spl[b][24:0];
         r.slope = scale_slope(slope[b]);
         if (periodic_ff) begin
            r.node = 16'((base + b) % nx);
            r.off_grid = 1'b0;
         end else begin
            r.node = node[15:0];
            r.off_grid = (node < 0 || node > nx - 1);
         end
         r.last = (b + 1 == ord);
         nodes_due.push_back(r);
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      node_result_type want;
      if (reset) begin
         periodic_ff <= 1'b0;
         order_ff    <= ORDER_RST;
         grid_ff     <= GRID_RST;
         pscale_ff   <= PSCALE_RST;
         dscale_ff   <= DSCALE_RST;
         tol_ff      <= TOL_RST;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_PERIODIC: periodic_ff <= pwdata[0];
               REG_ORDER:    order_ff    <= pwdata[ORDER_W-1:0];
               REG_GRID:     grid_ff     <= pwdata[GRID_W-1:0];
               REG_PSCALE:   pscale_ff   <= pwdata;
               REG_DSCALE:   dscale_ff   <= pwdata;
               REG_TOL:      tol_ff      <= pwdata[TOL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_nodes(req_coordinate);
         if (rsp_valid && !rsp_stall) begin
            if (nodes_due.size() == 0) begin
               report_mismatch("unexpected result, weight", rsp_weight, 0);
            end else begin
               want = nodes_due.pop_front();
               if (rsp_weight !== want.weight)
                  report_mismatch("weight", rsp_weight, want.weight);
               if (rsp_weight_derivative !== want.slope)
                  report_mismatch("weight_derivative", rsp_weight_derivative,
                                  $signed(want.slope));
               if (rsp_node_index !== want.node)
                  report_mismatch("node_index", rsp_node_index, want.node);
               if (rsp_index_error !== want.off_grid)
                  report_mismatch("index_error", rsp_index_error, want.off_grid);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
      end
   end

endmodule

/* bench/tb_bspline_grid_weights.sv */
// Testbench top for the B-spline weight block: clock, reset, stimulus phases and verdict.
module tb_bspline_grid_weights;
   import bgw_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [COORD_W-1:0]  req_coordinate = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [24:0]                rsp_weight;
   logic signed [DER_W-1:0]    rsp_weight_derivative;
   logic [15:0]                rsp_node_index;
   logic                       rsp_index_error;
   logic                       rsp_last;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      paddr = '0;
   logic [CSR_DATA_W-1:0]      pwdata = '0;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;

   int fail_count;
   int results_due;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_span = 0;
   int cur_grid = 64;

   always #2 clock = ~clock;

   bspline_grid_weights u_top (.*);

   bgw_checker u_checker (.*);

   // Receiver: switch between no stalls, sparse stalls and heavy stalls every so often.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_span <= $urandom_range(10, 80);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   // Watchdog: end the run if no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Register write: setup cycle, then access cycle; the write lands at the access edge.
   task automatic csr_write(logic [2:0] idx, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one coordinate and hold it until the block takes it; return at the accepting edge.
   task automatic send_coordinate(logic [31:0] coord);
      req_valid      <= 1'b1;
      req_coordinate <= coord;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   // Drop valid for a random gap, but only when the gap is non-zero so valid stays high in bursts.
   task automatic maybe_gap(inout int burst_left);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid and hold off until every expected result has come.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_registers(logic pm, logic [3:0] ord, logic [15:0] grid,
                                logic [31:0] ps, logic [31:0] ds, logic [7:0] tol);
      csr_write(REG_PERIODIC, {31'd0, pm});
      csr_write(REG_ORDER, {28'd0, ord});
      csr_write(REG_GRID, {16'd0, grid});
      csr_write(REG_PSCALE, ps);
      csr_write(REG_DSCALE, ds);
      csr_write(REG_TOL, {24'd0, tol});
      cur_grid = (grid < 2) ? 2 : grid;
   endtask

   // Mostly positions on or near the grid (unit scale in mind), with cell-edge hits and noise.
   function automatic logic [31:0] pick_coordinate();
      int span;
      span = (cur_grid > 300) ? 300 : cur_grid;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, (span + 4) * 65536) - 2 * 65536;
         5, 6:          return ($urandom_range(0, span) << 16) + $urandom_range(0, 511) - 256;
         7:             return (cur_grid << 16) - $urandom_range(0, 70000);
         default:       return $urandom();
      endcase
   endfunction

   initial begin
      int burst_left;
      logic [31:0] ps, ds;
      logic [15:0] grid;
      logic [3:0] ord;
      logic [31:0] edge_coords[$];
      burst_left = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults: order four on an open grid of 64 nodes; hit extremes, cell edges and ends.
      edge_coords = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1,
                      32'h8000, 32'h7FFF, 32'h0000_FFFF, 32'h003F_0000, 32'h003E_FFFF,
                      32'h003F_0001, 32'h0040_0000, 32'h0020_8000, 32'h0001_0000};
      foreach (edge_coords[j]) send_coordinate(edge_coords[j]);
      drain();

      // Nearest-node order on the smallest periodic grid, every scale at its top.
      set_registers(1'b1, 4'd1, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
      foreach (edge_coords[j]) if (j < 5) send_coordinate(edge_coords[j]);
      drain();

      // Highest order on the widest open grid, zero scales, zero tolerance.
      set_registers(1'b0, 4'd8, 16'hFFFF, 32'd0, 32'd0, 8'd0);
      send_coordinate(32'h1234_5678);
      send_coordinate(32'h8000_0000);
      drain();

      // Out-of-range orders and the full tolerance on an open grid.
      set_registers(1'b0, 4'd0, 16'd1, 32'd65536, 32'd65536, 8'd255);
      send_coordinate(32'h0000_FFFF);
      send_coordinate(32'h0001_0001);
      drain();
      csr_write(REG_ORDER, 32'd15);
      send_coordinate(32'h0000_8000);
      send_coordinate(32'h0002_0000);
      drain();

      // Random phases: new settings each time, then a run of bursty coordinates.
      for (int phase = 0; phase < 12; phase++) begin
         ord = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 8));
         case ($urandom_range(0, 5))
            0:       grid = 16'($urandom_range(0, 3));
            1:       grid = 16'hFFFF;
            default: grid = 16'($urandom_range(2, 200));
         endcase
         case ($urandom_range(0, 5))
            0:       ps = $urandom();
            1:       ps = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
            2:       ps = $urandom_range(16384, 262144);
            default: ps = 32'd65536;
         endcase
         case ($urandom_range(0, 3))
            0:       ds = $urandom();
            1:       ds = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
            default: ds = $urandom_range(0, 1 << 20);
         endcase
         set_registers(1'($urandom_range(0, 1)), ord, grid, ps, ds,
                       ($urandom_range(0, 2) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3)));
         for (int n = 0; n < 30; n++) begin
            send_coordinate(pick_coordinate());
            maybe_gap(burst_left);
         end
         drain();
      end

      // All stimulus is in and drained; allow the pipeline a margin, then give the verdict.
      repeat (40) @(posedge clock);
      if (fail_count == 0 && results_due == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
